// ----- hdl/pcxrle_pkg.sv -----
// ============================================================================
// pcxrle_pkg : shared types and constants of the PCX RLE scan-line decoder
// Command word passed from the byte classifier to the pixel expander, the
// configuration register set and the result status codes.
// ============================================================================
`default_nettype none

package pcxrle_pkg;

    localparam int CFG_W   = 11;  // width of each configuration register
    localparam int RUN_W   = 6;   // run count field of a header byte
    localparam int COORD_W = 10;  // width of the x and y result fields

    localparam logic [1:0] HDR_MARK = 2'b11;  // top bits of a run header

    // Configuration register indexes
    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_LINE_BYTES   = 2'd1;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd2;

    localparam logic [CFG_W-1:0] RST_IMAGE_WIDTH  = 11'd320;
    localparam logic [CFG_W-1:0] RST_LINE_BYTES   = 11'd320;
    localparam logic [CFG_W-1:0] RST_IMAGE_HEIGHT = 11'd200;

    // Result status codes
    localparam logic [1:0] ST_PIXEL = 2'd0;
    localparam logic [1:0] ST_ERROR = 2'd1;
    localparam logic [1:0] ST_DONE  = 2'd2;

    // Command queue depth
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [0:0] {
        CMD_PIXELS = 1'b0,
        CMD_ERROR  = 1'b1
    } cmd_kind_t;

    typedef struct packed {
        logic [CFG_W-1:0] image_width;
        logic [CFG_W-1:0] line_bytes;
        logic [CFG_W-1:0] image_height;
    } cfg_t;

    // One command word: a span of visible pixels, optionally followed by
    // the image complete item, or a single error item.
    typedef struct packed {
        cmd_kind_t        kind;
        logic [7:0]       value;
        logic [CFG_W-1:0] x;
        logic [CFG_W-1:0] y;
        logic [RUN_W-1:0] count;
        logic             done;
    } cmd_t;

endpackage

`default_nettype wire

// ----- hdl/pcxrle_front.sv -----
// ============================================================================
// pcxrle_front : byte classifier of the PCX RLE decoder
// Accepts coded bytes, tracks run header, column and row, checks geometry
// and turns each byte into at most one command word for the expander.
// ============================================================================
`default_nettype none

module pcxrle_front
    import pcxrle_pkg::*;
#(
    parameter int MAX_LINE = 1024,
    parameter int MAX_ROWS = 1024
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire cfg_t       cfg,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_encoded_byte,
    input  wire logic       s_end_of_data,
    output logic            push,
    output cmd_t            push_cmd,
    input  wire logic       q_full
);

    logic             pending_reg,  pending_next;
    logic [RUN_W-1:0] run_len_reg,  run_len_next;
    logic [CFG_W-1:0] col_reg,      col_next;
    logic [CFG_W-1:0] row_reg,      row_next;
    logic             failed_reg,   failed_next;
    logic             finished_reg, finished_next;

    logic             take;
    logic             geom_bad;
    logic             is_hdr;
    logic [RUN_W-1:0] cnt_eff;
    logic [CFG_W-1:0] rem;
    logic             overrun;
    logic [CFG_W-1:0] col_sum;
    logic [CFG_W-1:0] row_inc;
    logic             eol;
    logic             img_done;
    logic [CFG_W-1:0] avail;
    logic [RUN_W-1:0] vis;

    assign s_ready = !q_full;
    assign take    = s_valid && s_ready;

    always_comb begin
        geom_bad = (cfg.image_width == '0) || (cfg.line_bytes == '0)
                || (cfg.image_height == '0)
                || (cfg.line_bytes < cfg.image_width)
                || (32'(cfg.line_bytes) > 32'(MAX_LINE))
                || (32'(cfg.image_height) > 32'(MAX_ROWS))
                || (col_reg >= cfg.line_bytes)
                || (row_reg >= cfg.image_height);

        is_hdr   = !pending_reg && (s_encoded_byte[7:6] == HDR_MARK);
        cnt_eff  = pending_reg ? run_len_reg : RUN_W'(1);
        rem      = cfg.line_bytes - col_reg;
        overrun  = CFG_W'(cnt_eff) > rem;
        col_sum  = col_reg + CFG_W'(cnt_eff);
        row_inc  = row_reg + CFG_W'(1);
        eol      = (col_sum == cfg.line_bytes);
        img_done = eol && (row_inc == cfg.image_height);

        // visible part of the span: clip at the image width
        avail = cfg.image_width - col_reg;
        if (col_reg >= cfg.image_width) begin
            vis = '0;
        end else if (CFG_W'(cnt_eff) <= avail) begin
            vis = cnt_eff;
        end else begin
            vis = avail[RUN_W-1:0];
        end
    end

    always_comb begin
        pending_next  = pending_reg;
        run_len_next  = run_len_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        failed_next   = failed_reg;
        finished_next = finished_reg;
        push          = 1'b0;
        push_cmd.kind  = CMD_PIXELS;
        push_cmd.value = s_encoded_byte;
        push_cmd.x     = col_reg;
        push_cmd.y     = row_reg;
        push_cmd.count = vis;
        push_cmd.done  = img_done;

        if (take && !failed_reg && !finished_reg) begin
            if (s_end_of_data || geom_bad || (is_hdr && s_encoded_byte[5:0] == '0)
                    || (!is_hdr && overrun)) begin
                // error: report once, then drop everything
                failed_next    = 1'b1;
                pending_next   = 1'b0;
                push           = 1'b1;
                push_cmd.kind  = CMD_ERROR;
                push_cmd.count = '0;
                push_cmd.done  = 1'b0;
            end else if (is_hdr) begin
                pending_next = 1'b1;
                run_len_next = s_encoded_byte[RUN_W-1:0];
            end else begin
                pending_next  = 1'b0;
                col_next      = eol ? '0 : col_sum;
                row_next      = eol ? row_inc : row_reg;
                finished_next = img_done;
                push          = (vis != '0) || img_done;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg  <= 1'b0;
            run_len_reg  <= '0;
            col_reg      <= '0;
            row_reg      <= '0;
            failed_reg   <= 1'b0;
            finished_reg <= 1'b0;
        end else begin
            pending_reg  <= pending_next;
            run_len_reg  <= run_len_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            failed_reg   <= failed_next;
            finished_reg <= finished_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/pcxrle_queue.sv -----
// ============================================================================
// pcxrle_queue : command queue of the PCX RLE decoder
// Small FIFO that decouples the byte classifier from the pixel expander.
// ============================================================================
`default_nettype none

module pcxrle_queue
    import pcxrle_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    output logic      full,
    input  wire logic pop,
    output logic      q_valid,
    output cmd_t      q_cmd
);

    cmd_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg,    cnt_next;
    logic              do_push, do_pop;

    assign full    = (cnt_reg == QCNT_W'(QDEPTH));
    assign q_valid = (cnt_reg != '0);
    assign q_cmd   = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push) begin
            wr_ptr_next = (32'(wr_ptr_reg) == QDEPTH - 1) ? '0 : wr_ptr_reg + QPTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (32'(rd_ptr_reg) == QDEPTH - 1) ? '0 : rd_ptr_reg + QPTR_W'(1);
        end
        cnt_next = cnt_reg + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/pcxrle_back.sv -----
// ============================================================================
// pcxrle_back : pixel expander of the PCX RLE decoder
// Takes command words from the queue and emits one result word per cycle
// while m_ready is high and no command is loading, through a registered output stage.
// ============================================================================
`default_nettype none

module pcxrle_back
    import pcxrle_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              q_valid,
    input  wire cmd_t              q_cmd,
    output logic                   pop,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [1:0]             m_status,
    output logic [7:0]             m_pixel_value,
    output logic [COORD_W-1:0]     m_pixel_x,
    output logic [COORD_W-1:0]     m_pixel_y,
    output logic                   m_last
);

    logic             active_reg, active_next;
    cmd_kind_t        kind_reg,   kind_next;
    logic [7:0]       val_reg,    val_next;
    logic [CFG_W-1:0] x_reg,      x_next;
    logic [CFG_W-1:0] y_reg,      y_next;
    logic [RUN_W-1:0] rem_reg,    rem_next;
    logic             done_reg,   done_next;

    logic               mv_reg,    mv_next;
    logic [1:0]         st_reg,    st_next;
    logic [7:0]         pv_reg,    pv_next;
    logic [COORD_W-1:0] px_reg,    px_next;
    logic [COORD_W-1:0] py_reg,    py_next;
    logic               last_reg,  last_next;

    logic out_free;

    assign out_free = !mv_reg || m_ready;
    assign pop      = !active_reg && q_valid;

    always_comb begin
        active_next = active_reg;
        kind_next   = kind_reg;
        val_next    = val_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        rem_next    = rem_reg;
        done_next   = done_reg;
        mv_next     = mv_reg && !m_ready;
        st_next     = st_reg;
        pv_next     = pv_reg;
        px_next     = px_reg;
        py_next     = py_reg;
        last_next   = last_reg;

        if (pop) begin
            // load the next command
            active_next = 1'b1;
            kind_next   = q_cmd.kind;
            val_next    = q_cmd.value;
            x_next      = q_cmd.x;
            y_next      = q_cmd.y;
            rem_next    = q_cmd.count;
            done_next   = q_cmd.done;
        end else if (active_reg && out_free) begin
            mv_next = 1'b1;
            if (rem_reg != '0) begin
                st_next   = ST_PIXEL;
                pv_next   = val_reg;
                px_next   = x_reg[COORD_W-1:0];
                py_next   = y_reg[COORD_W-1:0];
                last_next = (rem_reg == RUN_W'(1)) && !done_reg;
                rem_next  = rem_reg - RUN_W'(1);
                x_next    = x_reg + CFG_W'(1);
                if (last_next) begin
                    active_next = 1'b0;
                end
            end else begin
                st_next     = (kind_reg == CMD_ERROR) ? ST_ERROR : ST_DONE;
                pv_next     = '0;
                px_next     = '0;
                py_next     = '0;
                last_next   = 1'b1;
                active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            mv_reg     <= 1'b0;
        end else begin
            active_reg <= active_next;
            mv_reg     <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg <= kind_next;
        val_reg  <= val_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        rem_reg  <= rem_next;
        done_reg <= done_next;
        st_reg   <= st_next;
        pv_reg   <= pv_next;
        px_reg   <= px_next;
        py_reg   <= py_next;
        last_reg <= last_next;
    end

    assign m_valid       = mv_reg;
    assign m_status      = st_reg;
    assign m_pixel_value = pv_reg;
    assign m_pixel_x     = px_reg;
    assign m_pixel_y     = py_reg;
    assign m_last        = last_reg;

    a_end_items_last : assert property (@(posedge aclk) disable iff (!aresetn)
        mv_reg && (st_reg == ST_ERROR || st_reg == ST_DONE) |-> last_reg)
        else $error("error or complete word without last");

    a_end_items_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        mv_reg && st_reg != ST_PIXEL |-> pv_reg == '0 && px_reg == '0 && py_reg == '0)
        else $error("error or complete word carries pixel data");

    a_status_code : assert property (@(posedge aclk) disable iff (!aresetn)
        mv_reg |-> (st_reg == ST_PIXEL || st_reg == ST_ERROR || st_reg == ST_DONE))
        else $error("undefined status code");

    a_last_ends_cmd : assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg && out_free && !pop && last_next |=> !active_reg)
        else $error("expander still busy after last word");

endmodule

`default_nettype wire

// ----- hdl/pcx_rle_scanline_decoder_top.sv -----
// ============================================================================
// pcx_rle_scanline_decoder_top : PCX RLE decoder for 8-bit single-plane data
// Decodes the run-length coded image bytes into (x, y, value) pixel words.
// ============================================================================
//
// Usage
//   Input channel (s_*): one coded byte per word, with s_end_of_data marking
//   exhaustion of the data. Output channel (m_*): pixel words, one format
//   error word or one image complete word; m_last marks the final word
//   caused by a given input byte.
//   Configuration: write image width, line bytes and image height through
//   cfg_wr_en / cfg_index / cfg_wdata while the decoder is idle.
//   Timing: the classifier turns an accepted byte into a command word that
//   is written into a two-entry queue; a header byte gives no command. The
//   expander loads each command from the queue and then emits one result
//   word per cycle while m_ready is high. A result passes the queue, the
//   expander's command registers and the registered output stage before it
//   reaches the receiver.
//   Reset: aresetn low restores the registers (320, 320, 200) and clears the
//   column, row, run and error state; the queue and output stage empty.
//   Stall: when m_ready is low the output word holds, the expander waits,
//   and the classifier keeps taking bytes until the queue fills.
// ============================================================================
`default_nettype none

module pcx_rle_scanline_decoder_top
    import pcxrle_pkg::*;
#(
    parameter int MAX_LINE = 1024,
    parameter int MAX_ROWS = 1024
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // configuration write port
    input  wire logic               cfg_wr_en,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [CFG_W-1:0]   cfg_wdata,
    // coded byte input
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [7:0]         s_encoded_byte,
    input  wire logic               s_end_of_data,
    // result output
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [1:0]              m_status,
    output logic [7:0]              m_pixel_value,
    output logic [COORD_W-1:0]      m_pixel_x,
    output logic [COORD_W-1:0]      m_pixel_y,
    output logic                    m_last
);

    cfg_t cfg_reg, cfg_next;
    logic push, q_full, pop, q_valid;
    cmd_t push_cmd, q_cmd;

    // Configuration registers: unknown indexes are dropped
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  cfg_next.image_width  = cfg_wdata;
                REG_LINE_BYTES:   cfg_next.line_bytes   = cfg_wdata;
                REG_IMAGE_HEIGHT: cfg_next.image_height = cfg_wdata;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.image_width  <= RST_IMAGE_WIDTH;
            cfg_reg.line_bytes   <= RST_LINE_BYTES;
            cfg_reg.image_height <= RST_IMAGE_HEIGHT;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Classify bytes and track position
    pcxrle_front #(
        .MAX_LINE (MAX_LINE),
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_encoded_byte (s_encoded_byte),
        .s_end_of_data  (s_end_of_data),
        .push           (push),
        .push_cmd       (push_cmd),
        .q_full         (q_full)
    );

    // Hold commands between the two halves
    pcxrle_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd)
    );

    // Expand commands into result words
    pcxrle_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_cmd         (q_cmd),
        .pop           (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_pixel_value (m_pixel_value),
        .m_pixel_x     (m_pixel_x),
        .m_pixel_y     (m_pixel_y),
        .m_last        (m_last)
    );

endmodule

`default_nettype wire
